>>> rtl/bar_pkg.sv
// Shared types and constants for the block-ack reorder window.
package bar_pkg;

  localparam int unsigned WIN_DEF      = 64;
  localparam int unsigned CONTEXTS_DEF = 64;
  localparam int unsigned SN_W         = 12;
  localparam int unsigned SLOT_W       = 6;
  localparam int unsigned SLOTS        = 64;
  localparam int unsigned CNT_W        = 7;
  localparam int unsigned TAG_W        = 16;
  localparam int unsigned TIME_W       = 32;
  localparam int unsigned CTX_IN_W     = 6;
  localparam logic [15:0] TIMEOUT_RST  = 16'd100;

  typedef enum logic [1:0] {
    MODE_FRAME  = 2'd0,
    MODE_EXPIRE = 2'd1,
    MODE_FLUSH  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic {
    KIND_DELIVER = 1'b0,
    KIND_DROP    = 1'b1
  } kind_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_BEGIN,
    ST_SLIDE,
    ST_STORE,
    ST_SKIP,
    ST_RUN,
    ST_FLUSH,
    ST_DROP,
    ST_EMIT,
    ST_FINISH
  } state_t;

  // Per-context window record, kept in one memory word
  typedef struct packed {
    logic [SLOTS-1:0]  full;
    logic [TIME_W-1:0] deadline;
    logic [CNT_W-1:0]  held;
    logic              started;
    logic [SN_W-1:0]   head;
  } ctx_rec_t;

endpackage

>>> rtl/bar_tag_ram.sv
// Slot tag memory: one write port, one registered read port.
module bar_tag_ram #(
  parameter int unsigned AW = 12,
  parameter int unsigned DW = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  // write and registered read; data holds until the next read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/block_ack_reorder_window.sv
// Block-ack receive reorder window: top level with step sequencer and context memory.
// The block takes no new item until the current one is through its slot walk. When the item
// yields words the walk runs twice (a counting pass, then a replay that emits), each walk
// step going through the shared slot-step unit and each word through the EMIT state.
// Reset: synchronous; afterwards a clearing pass zeroes every context
// record while s_axis_tready stays low. Configuration writes are taken at any time.
module block_ack_reorder_window #(
  parameter int unsigned WIN      = bar_pkg::WIN_DEF,
  parameter int unsigned CONTEXTS = bar_pkg::CONTEXTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // context_req[5:0], seq_num[17:6], frame_tag[33:18],
                                      // now[65:34], zero[71:66]
  input  logic [1:0]  s_axis_tuser,   // mode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // out_tag[15:0], pending[16], zero[23:17]
  output logic        m_axis_tuser,   // kind[0]
  output logic        m_axis_tlast    // last
);

  localparam int unsigned CW  = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
  localparam int unsigned TAW = CW + bar_pkg::SLOT_W;
  localparam logic [bar_pkg::SN_W-1:0]  WIN_SN  = bar_pkg::SN_W'(WIN);
  localparam logic [bar_pkg::SN_W-1:0]  WIN_M1  = bar_pkg::SN_W'(WIN - 1);
  localparam logic [bar_pkg::CNT_W-1:0] WIN_CNT = bar_pkg::CNT_W'(WIN);
  localparam logic [bar_pkg::CNT_W-1:0] SLOTS_CNT = bar_pkg::CNT_W'(bar_pkg::SLOTS);
  localparam logic [CW-1:0] CLR_LAST = CW'(CONTEXTS - 1);

  bar_pkg::state_t   state, state_next, ret, ret_next;
  bar_pkg::ctx_rec_t rec, rec_next, snap, ctx_rd, ctx_wd;
  bar_pkg::ctx_rec_t ctx_mem [CONTEXTS];
  bar_pkg::mode_t    mode_q;
  bar_pkg::kind_t    emit_kind, emit_kind_next;

  logic [CW-1:0]                 ctx_addr_q, ctx_ra, ctx_wa, clr_idx;
  logic                          ctx_ok_q, ctx_we;
  logic [bar_pkg::SN_W-1:0]      sn_q;
  logic [bar_pkg::TAG_W-1:0]     tag_q, tag_rd;
  logic [bar_pkg::TIME_W-1:0]    now_q, time_diff;
  logic [15:0]                   timeout;
  logic                          pass2, pend;
  logic [bar_pkg::CNT_W-1:0]     cnt, cnt_next, res_cnt, res_cnt_next, n_res, last_idx;
  logic                          emit_src_in, emit_src_in_next;
  logic                          accept, out_free, out_load;
  logic                          tag_we, tag_re;
  logic [TAW-1:0]                tag_ra, tag_wa;

  logic [bar_pkg::SN_W-1:0]      head_eff, ahead, move;
  logic [bar_pkg::CNT_W-1:0]     walk;
  logic [bar_pkg::SLOT_W-1:0]    head_slot, sn_slot;
  logic                          head_full, is_old, is_far, expired, held_nz;

  logic                          out_kind, out_last, out_pend;
  logic [bar_pkg::TAG_W-1:0]     out_tag;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == bar_pkg::ST_IDLE);
  assign ctx_ra        = CW'(s_axis_tdata[5:0]);
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // Shared slot-step unit inputs
  assign head_slot = rec.head[bar_pkg::SLOT_W-1:0];
  assign sn_slot   = sn_q[bar_pkg::SLOT_W-1:0];
  assign head_full = rec.full[head_slot];
  assign held_nz   = (rec.held != '0);
  assign head_eff  = rec.started ? rec.head : sn_q;
  assign ahead     = sn_q - head_eff;
  assign is_old    = ahead[bar_pkg::SN_W-1];
  assign is_far    = (ahead >= WIN_SN);
  assign move      = ahead - WIN_SN + 12'd1;
  assign walk      = (move < WIN_SN) ? move[bar_pkg::CNT_W-1:0] : WIN_CNT;
  assign time_diff = now_q - rec.deadline;
  assign expired   = !time_diff[bar_pkg::TIME_W-1];
  assign last_idx  = n_res - 7'd1;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      bar_pkg::ST_CLEAR:  if (clr_idx == CLR_LAST) state_next = bar_pkg::ST_IDLE;
      bar_pkg::ST_IDLE:   if (accept) state_next = bar_pkg::ST_LOAD;
      bar_pkg::ST_LOAD:   state_next = bar_pkg::ST_BEGIN;
      bar_pkg::ST_BEGIN: begin
        if (!ctx_ok_q) begin
          state_next = bar_pkg::ST_FINISH;
        end else begin
          case (mode_q)
            bar_pkg::MODE_FRAME: begin
              if (is_old) state_next = bar_pkg::ST_DROP;
              else if (is_far) state_next = bar_pkg::ST_SLIDE;
              else state_next = bar_pkg::ST_STORE;
            end
            bar_pkg::MODE_EXPIRE: begin
              if (held_nz && expired) state_next = bar_pkg::ST_SKIP;
              else state_next = bar_pkg::ST_FINISH;
            end
            bar_pkg::MODE_FLUSH: state_next = bar_pkg::ST_FLUSH;
            default:             state_next = bar_pkg::ST_FINISH;
          endcase
        end
      end
      bar_pkg::ST_SLIDE: begin
        if (cnt == '0) state_next = bar_pkg::ST_STORE;
        else if (head_full && pass2) state_next = bar_pkg::ST_EMIT;
      end
      bar_pkg::ST_STORE: begin
        if (rec.full[sn_slot]) state_next = bar_pkg::ST_DROP;
        else state_next = bar_pkg::ST_RUN;
      end
      bar_pkg::ST_SKIP: begin
        if (cnt == '0 || head_full) state_next = bar_pkg::ST_RUN;
      end
      bar_pkg::ST_RUN: begin
        if (!(held_nz && head_full)) state_next = bar_pkg::ST_FINISH;
        else if (pass2) state_next = bar_pkg::ST_EMIT;
      end
      bar_pkg::ST_FLUSH: begin
        if (!held_nz || cnt == '0) state_next = bar_pkg::ST_FINISH;
        else if (head_full && pass2) state_next = bar_pkg::ST_EMIT;
      end
      bar_pkg::ST_DROP: begin
        if (pass2) state_next = bar_pkg::ST_EMIT;
        else state_next = bar_pkg::ST_FINISH;
      end
      bar_pkg::ST_EMIT:   if (out_free) state_next = ret;
      bar_pkg::ST_FINISH: begin
        if (pass2 || res_cnt == '0) state_next = bar_pkg::ST_IDLE;
        else state_next = bar_pkg::ST_BEGIN;
      end
      default: state_next = bar_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    rec_next         = rec;
    cnt_next         = cnt;
    res_cnt_next     = res_cnt;
    ret_next         = ret;
    emit_kind_next   = emit_kind;
    emit_src_in_next = emit_src_in;
    tag_we           = 1'b0;
    tag_re           = 1'b0;
    tag_ra           = {ctx_addr_q, head_slot};
    tag_wa           = {ctx_addr_q, sn_slot};
    ctx_we           = 1'b0;
    ctx_wa           = ctx_addr_q;
    ctx_wd           = rec;
    out_load         = 1'b0;
    case (state)
      bar_pkg::ST_CLEAR: begin
        ctx_we = 1'b1;
        ctx_wa = clr_idx;
        ctx_wd = '0;
      end
      bar_pkg::ST_LOAD: begin
        rec_next     = ctx_rd;
        res_cnt_next = '0;
      end
      bar_pkg::ST_BEGIN: begin
        case (mode_q)
          bar_pkg::MODE_FRAME: begin
            rec_next.head    = head_eff;
            rec_next.started = 1'b1;
            cnt_next         = walk;
          end
          bar_pkg::MODE_EXPIRE: cnt_next = WIN_CNT;
          bar_pkg::MODE_FLUSH:  cnt_next = SLOTS_CNT;
          default:              cnt_next = cnt;
        endcase
        if (!ctx_ok_q) rec_next = rec;
      end
      bar_pkg::ST_SLIDE, bar_pkg::ST_RUN, bar_pkg::ST_FLUSH: begin
        // step the head past one slot, taking its frame out if held, or end a slide or a flush
        if ((state == bar_pkg::ST_SLIDE && cnt == '0)) begin
          rec_next.head = sn_q - WIN_M1;
        end else if (state == bar_pkg::ST_FLUSH && (!held_nz || cnt == '0)) begin
          rec_next.full    = '0;
          rec_next.held    = '0;
          rec_next.started = 1'b0;
        end else if (state != bar_pkg::ST_RUN || (held_nz && head_full)) begin
          rec_next.head = rec.head + 12'd1;
          if (state != bar_pkg::ST_RUN) cnt_next = cnt - 7'd1;
          if (head_full) begin
            rec_next.full[head_slot] = 1'b0;
            rec_next.held            = rec.held - 7'd1;
            if (pass2) begin
              tag_re           = 1'b1;
              ret_next         = state;
              emit_src_in_next = 1'b0;
              emit_kind_next   = (state == bar_pkg::ST_FLUSH) ? bar_pkg::KIND_DROP
                                                               : bar_pkg::KIND_DELIVER;
            end else begin
              res_cnt_next = res_cnt + 7'd1;
            end
          end
        end
      end
      bar_pkg::ST_STORE: begin
        if (!rec.full[sn_slot]) begin
          rec_next.full[sn_slot] = 1'b1;
          rec_next.held          = rec.held + 7'd1;
          rec_next.deadline      = now_q + bar_pkg::TIME_W'(timeout);
          // write the tag only once no earlier slide read of a replay can still need the old one
          tag_we                 = pass2 || (res_cnt == '0);
        end
      end
      bar_pkg::ST_SKIP: begin
        if (!(cnt == '0 || head_full)) begin
          rec_next.head = rec.head + 12'd1;
          cnt_next      = cnt - 7'd1;
        end
      end
      bar_pkg::ST_DROP: begin
        if (pass2) begin
          ret_next         = bar_pkg::ST_FINISH;
          emit_src_in_next = 1'b1;
          emit_kind_next   = bar_pkg::KIND_DROP;
        end else begin
          res_cnt_next = res_cnt + 7'd1;
        end
      end
      bar_pkg::ST_EMIT: begin
        if (out_free) begin
          out_load     = 1'b1;
          res_cnt_next = res_cnt + 7'd1;
        end
      end
      bar_pkg::ST_FINISH: begin
        if (pass2 || res_cnt == '0) begin
          ctx_we = ctx_ok_q;
        end else begin
          rec_next     = snap;
          res_cnt_next = '0;
        end
      end
      default: rec_next = rec;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bar_pkg::ST_CLEAR;
      clr_idx   <= '0;
      pass2     <= 1'b0;
      timeout   <= bar_pkg::TIMEOUT_RST;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == bar_pkg::ST_CLEAR) clr_idx <= clr_idx + CW'(1);
      if (state == bar_pkg::ST_LOAD) pass2 <= 1'b0;
      else if (state == bar_pkg::ST_FINISH) pass2 <= 1'b1;
      if (cfg_wr_en) timeout <= cfg_wr_data;
      if (out_load) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rec         <= rec_next;
    cnt         <= cnt_next;
    res_cnt     <= res_cnt_next;
    ret         <= ret_next;
    emit_kind   <= emit_kind_next;
    emit_src_in <= emit_src_in_next;
    if (accept) begin
      mode_q     <= bar_pkg::mode_t'(s_axis_tuser);
      ctx_addr_q <= ctx_ra;
      ctx_ok_q   <= (32'(s_axis_tdata[5:0]) < 32'(CONTEXTS));
      sn_q       <= s_axis_tdata[17:6];
      tag_q      <= s_axis_tdata[33:18];
      now_q      <= s_axis_tdata[65:34];
    end
    if (state == bar_pkg::ST_LOAD) snap <= ctx_rd;
    if (state == bar_pkg::ST_FINISH && !pass2) begin
      n_res <= res_cnt;
      pend  <= held_nz;
    end
    if (out_load) begin
      out_kind <= emit_kind;
      out_tag  <= emit_src_in ? tag_q : tag_rd;
      out_last <= (res_cnt == last_idx);
      out_pend <= pend;
    end
  end

  // Context record memory
  always_ff @(posedge clk) begin
    if (ctx_we) ctx_mem[ctx_wa] <= ctx_wd;
    if (accept) ctx_rd <= ctx_mem[ctx_ra];
  end

  bar_tag_ram #(
    .AW (TAW),
    .DW (bar_pkg::TAG_W)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_wa),
    .wdata (tag_q),
    .re    (tag_re),
    .raddr (tag_ra),
    .rdata (tag_rd)
  );

  assign m_axis_tdata = {7'd0, out_pend, out_tag};
  assign m_axis_tuser = out_kind;
  assign m_axis_tlast = out_last;

`ifndef SYNTHESIS
  // held count agrees with the slot bitmap at the start of each pass
  a_held_bits: assert property (@(posedge clk) disable iff (rst)
    state == bar_pkg::ST_BEGIN && ctx_ok_q |-> $countones(rec.full) == 32'(rec.held))
    else $error("held count disagrees with slot bitmap");

  // replay never emits more words than the counting pass found
  a_emit_bound: assert property (@(posedge clk) disable iff (rst)
    state == bar_pkg::ST_EMIT |-> res_cnt < n_res)
    else $error("replay emits beyond counted results");

  // replay ends with exactly the counted number of words
  a_emit_total: assert property (@(posedge clk) disable iff (rst)
    state == bar_pkg::ST_FINISH && pass2 |-> res_cnt == n_res)
    else $error("replay word count mismatch");

  // no word is loaded and no tag is written while the input side is open
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !out_load && !tag_we)
    else $error("activity while idle");
`endif

endmodule
